[rtl/hrcm_pkg.sv]
// ----------------------------------------------------------------------------
// hrcm_pkg
// Shared types, sizes and helpers for the Hamming ratio cross-check matcher.
// ----------------------------------------------------------------------------
package hrcm_pkg;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned IdxW       = 6;   // index into one descriptor set
  localparam int unsigned CntW       = 7;   // set fill count, 0..MaxEntries
  localparam int unsigned DistW      = 9;   // Hamming distance, 0..256
  localparam int unsigned DescW      = 256;
  localparam int unsigned RatioW     = 9;
  localparam int unsigned ChoiceW    = IdxW + 1;  // {ok, index}

  // transfer kinds on the input stream
  localparam logic [1:0] KindLoadA = 2'd0;
  localparam logic [1:0] KindLoadB = 2'd1;
  localparam logic [1:0] KindRun   = 2'd2;

  // search direction; reverse pass fills B->A choices, forward pass A->B
  localparam logic DirRev = 1'b0;
  localparam logic DirFwd = 1'b1;

  // config register byte addresses
  localparam logic [2:0] RegRatioAddr = 3'd0;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RUN   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_ERD   = 5'b01000,
    S_ELD   = 5'b10000
  } state_e;

  typedef struct packed {
    logic            dir;
    logic            first;
    logic            last;
    logic [IdxW-1:0] outer;
    logic [IdxW-1:0] inner;
  } pair_tag_t;

  // SWAR population count of one 64-bit word
  function automatic logic [6:0] popcount64(input logic [63:0] w);
    logic [63:0] v;
    logic [6:0]  s;
    v = w - ((w >> 1) & 64'h5555555555555555);
    v = (v & 64'h3333333333333333) + ((v >> 2) & 64'h3333333333333333);
    v = (v + (v >> 4)) & 64'h0F0F0F0F0F0F0F0F;
    s = 7'(v[7:0]) + 7'(v[15:8]) + 7'(v[23:16]) + 7'(v[31:24])
      + 7'(v[39:32]) + 7'(v[47:40]) + 7'(v[55:48]) + 7'(v[63:56]);
    return s;
  endfunction

endpackage

[rtl/hrcm_popdist.sv]
// ----------------------------------------------------------------------------
// hrcm_popdist
// Hamming distance of two 256-bit descriptors: per-word counts registered,
// word sum combinational on the output.
// ----------------------------------------------------------------------------
module hrcm_popdist (
  input  logic                      clk_i,
  input  logic [hrcm_pkg::DescW-1:0] x_i,
  input  logic [hrcm_pkg::DescW-1:0] y_i,
  output logic [hrcm_pkg::DistW-1:0] dist_o
);
  import hrcm_pkg::*;

  logic [DescW-1:0] diff;
  logic [6:0]       pc_q [4];

  assign diff = x_i ^ y_i;

  always_ff @(posedge clk_i) begin
    for (int w = 0; w < 4; w++) begin
      pc_q[w] <= popcount64(diff[w*64 +: 64]);
    end
  end

  assign dist_o = DistW'(pc_q[0]) + DistW'(pc_q[1]) + DistW'(pc_q[2]) + DistW'(pc_q[3]);

endmodule

[rtl/hamming_ratio_crosscheck_matcher_unit.sv]
// ----------------------------------------------------------------------------
// hamming_ratio_crosscheck_matcher_unit
// Brute-force mutual nearest-neighbor matcher for 256-bit binary descriptors
// with nearest/second ratio test and B->A cross check.
// ----------------------------------------------------------------------------
//  channel   | dir | payload
//  s_axis    | in  | tuser = kind, tdata = desc_word0..3 (256 bits)
//  m_axis    | out | tdata = query_index, match_index, matched, match_count,
//            |     |         overflow (21 bits in 24), tlast = last
//  apb       | in  | reg 0 at 0x0: ratio_q8 (9 bits, reset 204)
//
//  A run compares one descriptor pair per cycle, read through the two read
//  ports of the descriptor memory, in a reverse and then a forward pass, then
//  emits one result per A entry through a choice read and a result load.
//  Output stalls hold the emit sequencer; input is taken only when no run is
//  in progress. Reset clears counts, overflow and control; the memories are
//  not cleared (entries past the counts are never read).
// ----------------------------------------------------------------------------
module hamming_ratio_crosscheck_matcher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [255:0] s_axis_tdata_i,  // desc_word0, desc_word1, desc_word2, desc_word3
  input  logic [1:0]  s_axis_tuser_i,   // kind
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // query_index, match_index, matched,
                                        // match_count, overflow, zero pad
  output logic        m_axis_tlast_o,   // last
  // config
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import hrcm_pkg::*;

  // -------------------------------------------------------------- config
  logic [RatioW-1:0] ratio_q;

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == RegRatioAddr[2]) ? 32'(ratio_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RatioW'(204);
    end else if (psel_i && penable_i && pwrite_i && (paddr_i[2] == RegRatioAddr[2])) begin
      ratio_q <= pwdata_i[RatioW-1:0];
    end
  end

  // -------------------------------------------------------------- control state
  state_e            state_q, state_d;
  logic [CntW-1:0]   count_a_q, count_a_d, count_b_q, count_b_d;
  logic              ovf_q, ovf_d;
  logic              dir_q, dir_d;
  logic [IdxW-1:0]   outer_q, outer_d, inner_q, inner_d;
  logic [IdxW-1:0]   emit_q, emit_d;
  logic [CntW-1:0]   total_q, total_d;

  logic s_fire;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  // -------------------------------------------------------------- descriptor memory
  // lower half set A, upper half set B; read A and B in the same cycle
  logic [DescW-1:0]  desc_mem [2*MaxEntries];
  logic              desc_we;
  logic [IdxW:0]     desc_waddr;
  logic [IdxW-1:0]   rd_a_addr, rd_b_addr;
  logic [DescW-1:0]  rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (desc_we) begin
      desc_mem[desc_waddr] <= s_axis_tdata_i;
    end
    rd_a_q <= desc_mem[{1'b0, rd_a_addr}];
    rd_b_q <= desc_mem[{1'b1, rd_b_addr}];
  end

  // -------------------------------------------------------------- choice memory
  // lower half reverse choices (per B entry), upper half forward (per A entry)
  logic [ChoiceW-1:0] choice_mem [2*MaxEntries];
  logic               ch_we;
  logic [IdxW:0]      ch_waddr, ch_raddr;
  logic [ChoiceW-1:0] ch_wdata, ch_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ch_we) begin
      choice_mem[ch_waddr] <= ch_wdata;
    end
    ch_rdata_q <= choice_mem[ch_raddr];
  end

  // -------------------------------------------------------------- pair pipeline
  // issue -> p1 (memory data) -> p2 (word counts) -> p3 (distance sum, track
  //       best/second) -> p4 (ratio test, reverse lookup) -> p5 (cross check,
  //       write back)
  logic       p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q;
  pair_tag_t  tag0, p1_tag_q, p2_tag_q, p3_tag_q;
  logic       issue;
  logic [CntW-1:0] n_inner, n_outer;
  logic       inner_last, outer_last;

  assign n_inner    = (dir_q == DirRev) ? count_a_q : count_b_q;
  assign n_outer    = (dir_q == DirRev) ? count_b_q : count_a_q;
  assign inner_last = (CntW'(inner_q) == n_inner - CntW'(1));
  assign outer_last = (CntW'(outer_q) == n_outer - CntW'(1));
  assign issue      = (state_q == S_RUN);

  assign rd_a_addr = (dir_q == DirRev) ? inner_q : outer_q;
  assign rd_b_addr = (dir_q == DirRev) ? outer_q : inner_q;

  always_comb begin
    tag0.dir   = dir_q;
    tag0.first = (inner_q == '0);
    tag0.last  = inner_last;
    tag0.outer = outer_q;
    tag0.inner = inner_q;
  end

  logic [DistW-1:0] pair_dist, pair_dist_q;

  hrcm_popdist u_popdist (
    .clk_i  (clk_i),
    .x_i    (rd_a_q),
    .y_i    (rd_b_q),
    .dist_o (pair_dist)
  );

  // running best / second tracker
  logic [DistW-1:0] best_q, best_d, second_q, second_d;
  logic             have2_q, have2_d;
  logic [IdxW-1:0]  idx_q, idx_d;

  always_comb begin
    best_d   = best_q;
    second_d = second_q;
    have2_d  = have2_q;
    idx_d    = idx_q;
    if (p3_v_q) begin
      if (p3_tag_q.first) begin
        best_d  = pair_dist_q;
        have2_d = 1'b0;
        idx_d   = p3_tag_q.inner;
      end else if (pair_dist_q < best_q) begin
        second_d = best_q;
        have2_d  = 1'b1;
        best_d   = pair_dist_q;
        idx_d    = p3_tag_q.inner;
      end else if (!have2_q || pair_dist_q < second_q) begin
        second_d = pair_dist_q;
        have2_d  = 1'b1;
      end
    end
  end

  // p4: ratio test on the finished tracker
  logic            p4_dir_q;
  logic [IdxW-1:0] p4_outer_q;
  logic [17:0]     lhs, rhs;
  logic            ratio_ok;

  assign lhs      = {1'b0, best_q, 8'd0};
  assign rhs      = 18'(second_q) * 18'(ratio_q);
  assign ratio_ok = have2_q ? (lhs < rhs) : (ratio_q != '0);

  logic            p5_dir_q, p5_ok_q;
  logic [IdxW-1:0] p5_outer_q, p5_idx_q;
  logic            mutual, fwd_ok;

  assign mutual = ch_rdata_q[IdxW] && (ch_rdata_q[IdxW-1:0] == p5_outer_q);
  assign fwd_ok = p5_ok_q && mutual;

  // emit states hold the forward-choice address so a stalled result keeps its data
  always_comb begin
    ch_we    = p5_v_q;
    ch_waddr = {p5_dir_q, p5_outer_q};
    ch_wdata = (p5_dir_q == DirRev) ? {p5_ok_q, p5_idx_q} : {fwd_ok, p5_idx_q};
    ch_raddr = (state_q == S_ERD || state_q == S_ELD) ? {DirFwd, emit_q} : {DirRev, idx_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      p5_v_q <= 1'b0;
    end else begin
      p1_v_q <= issue;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q && p3_tag_q.last;
      p5_v_q <= p4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_tag_q    <= tag0;
    p2_tag_q    <= p1_tag_q;
    p3_tag_q    <= p2_tag_q;
    pair_dist_q <= pair_dist;
    best_q      <= best_d;
    second_q    <= second_d;
    have2_q     <= have2_d;
    idx_q       <= idx_d;
    p4_dir_q    <= p3_tag_q.dir;
    p4_outer_q  <= p3_tag_q.outer;
    p5_dir_q    <= p4_dir_q;
    p5_outer_q  <= p4_outer_q;
    p5_ok_q     <= ratio_ok;
    p5_idx_q    <= idx_q;
  end

  logic pipe_empty;
  assign pipe_empty = !(p1_v_q || p2_v_q || p3_v_q || p4_v_q || p5_v_q);

  // -------------------------------------------------------------- result register
  logic            out_v_q;
  logic [23:0]     out_data_q;
  logic            out_last_q;
  logic            out_load;
  logic            emit_last, emit_match;

  assign emit_last  = (CntW'(emit_q) == count_a_q - CntW'(1));
  assign emit_match = ch_rdata_q[IdxW] && (count_b_q != '0);
  assign out_load   = (state_q == S_ELD) && (!out_v_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {3'd0,
                     ovf_q,
                     emit_last ? total_q : CntW'(0),
                     emit_match,
                     emit_match ? ch_rdata_q[IdxW-1:0] : IdxW'(0),
                     emit_q};
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // -------------------------------------------------------------- sequencer
  always_comb begin
    state_d    = state_q;
    count_a_d  = count_a_q;
    count_b_d  = count_b_q;
    ovf_d      = ovf_q;
    dir_d      = dir_q;
    outer_d    = outer_q;
    inner_d    = inner_q;
    emit_d     = emit_q;
    total_d    = total_q;
    desc_we    = 1'b0;
    desc_waddr = {s_axis_tuser_i[0], count_a_q[IdxW-1:0]};

    if (p5_v_q && p5_dir_q == DirFwd) begin
      total_d = total_q + CntW'(fwd_ok);
    end

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          case (s_axis_tuser_i)
            KindLoadA: begin
              if (count_a_q >= CntW'(MaxEntries)) begin
                ovf_d = 1'b1;
              end else begin
                desc_we    = 1'b1;
                desc_waddr = {1'b0, count_a_q[IdxW-1:0]};
                count_a_d  = count_a_q + CntW'(1);
              end
            end
            KindLoadB: begin
              if (count_b_q >= CntW'(MaxEntries)) begin
                ovf_d = 1'b1;
              end else begin
                desc_we    = 1'b1;
                desc_waddr = {1'b1, count_b_q[IdxW-1:0]};
                count_b_d  = count_b_q + CntW'(1);
              end
            end
            KindRun: begin
              total_d = '0;
              outer_d = '0;
              inner_d = '0;
              emit_d  = '0;
              dir_d   = DirRev;
              if (count_a_q == '0) begin
                count_b_d = '0;
                ovf_d     = 1'b0;
              end else if (count_b_q == '0) begin
                state_d = S_ERD;
              end else begin
                state_d = S_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (inner_last) begin
          inner_d = '0;
          outer_d = outer_q + IdxW'(1);
          if (outer_last) begin
            state_d = S_DRAIN;
          end
        end else begin
          inner_d = inner_q + IdxW'(1);
        end
      end
      S_DRAIN: begin
        // reverse choices must be written before the forward pass reads them
        if (pipe_empty) begin
          outer_d = '0;
          inner_d = '0;
          if (dir_q == DirRev) begin
            dir_d   = DirFwd;
            state_d = S_RUN;
          end else begin
            state_d = S_ERD;
          end
        end
      end
      S_ERD: begin
        state_d = S_ELD;
      end
      S_ELD: begin
        if (out_load) begin
          if (emit_last) begin
            state_d   = S_IDLE;
            count_a_d = '0;
            count_b_d = '0;
            ovf_d     = 1'b0;
          end else begin
            emit_d  = emit_q + IdxW'(1);
            state_d = S_ERD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_a_q <= '0;
      count_b_q <= '0;
      ovf_q     <= 1'b0;
      dir_q     <= DirRev;
      outer_q   <= '0;
      inner_q   <= '0;
      emit_q    <= '0;
      total_q   <= '0;
    end else begin
      state_q   <= state_d;
      count_a_q <= count_a_d;
      count_b_q <= count_b_d;
      ovf_q     <= ovf_d;
      dir_q     <= dir_d;
      outer_q   <= outer_d;
      inner_q   <= inner_d;
      emit_q    <= emit_d;
      total_q   <= total_d;
    end
  end

  // -------------------------------------------------------------- assertions
  a_wb_in_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p5_v_q |-> (state_q == S_RUN || state_q == S_DRAIN))
    else $error("choice write-back outside a matching pass");

  a_total_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (total_q <= count_a_q))
    else $error("match total exceeds set A size");

  a_emit_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ERD || state_q == S_ELD) |-> (count_a_q != '0))
    else $error("emitting results with empty set A");

  a_fwd_after_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && dir_q == DirFwd && $past(state_q) == S_DRAIN) |->
      $past(pipe_empty))
    else $error("forward pass started before reverse pass drained");

endmodule
